// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define FQSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FQSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FQSS_ASSERT(lbl, prop, msg)
`define FQSS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hdl/fqss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqss_pkg
// sizes, operation and status codes and slot arithmetic for the queue
// ----------------------------------------------------------------------------
package fqss_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(2 * DEPTH);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // operation codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_ROT    = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // storage slot of the entry at position pos from the front
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] fp,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(fp) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== hdl/fqss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fqss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/fifo_queue_sort_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_sort_search_top
// bounded fifo of signed words with push, pop, rotate, search and stable sort
// ----------------------------------------------------------------------------
// usage
//   a command word (opcode_i, operand_value_i) is taken at a clock edge with
//   start_i high and busy_o low. busy_o stays high while the command runs.
//   exactly one result word per command appears on the result ports for one
//   cycle with done_o high; the receiver cannot hold it off. done_o shows in
//   the cycle where busy_o is low again, so the next command may be started
//   in that same cycle.
//   push and pop update the queue, an unknown opcode leaves it as it is, and
//   each then reads the front word; rotate first moves the front word to the
//   rear slot; search compares the entries one by one; sort runs insertion
//   passes, so its run time grows with the entry count and the element moves
//   and is longest for reversed data.
// all entries live in one 16 x 32 ram with one read and one write port; the
// single read port, one entry per cycle, paces search and sort.
// reset clears the front pointer and count; the ram is not cleared, only
// words from occupied slots are ever used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_sort_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2:0]                    opcode_i,
  input  logic signed [31:0]            operand_value_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [31:0]            front_value_o,
  output logic [4:0]                    entry_count_o,
  output logic                          is_empty_o,
  output logic [3:0]                    match_index_o,
  output logic                          match_found_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned PtrW  = fqss_pkg::PTR_W;
  localparam int unsigned CntW  = fqss_pkg::CNT_W;
  localparam int unsigned WordW = fqss_pkg::WORD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;  // front word arriving, write it at rear
  localparam logic [2:0] S_SRCH  = 3'd2;  // compare one entry per cycle
  localparam logic [2:0] S_KEY   = 3'd3;  // pick up the next key of the sort
  localparam logic [2:0] S_CMP   = 3'd4;  // compare key with left neighbor, shift
  localparam logic [2:0] S_PUT   = 3'd5;  // key lands at the front position
  localparam logic [2:0] S_FRD   = 3'd6;  // read front slot
  localparam logic [2:0] S_FWAIT = 3'd7;  // front word arriving, build result

  logic [2:0]       state_q, state_d;
  logic [PtrW-1:0]  fp_q, fp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] key_q, key_d;
  logic [PtrW-1:0]  pos_q, pos_d;
  logic [PtrW-1:0]  jpos_q, jpos_d;
  logic [PtrW-1:0]  idx_q, idx_d;
  logic             found_q, found_d;
  logic [1:0]       status_q, status_d;
  logic [WordW-1:0] front_q, front_d;
  logic             done_q, done_d;

  // ram port
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;
  logic [PtrW-1:0]  rd_addr;
  logic [WordW-1:0] rd_data;

  // shared comparator: key register against the word read this cycle
  logic cmp_eq;
  logic cmp_lt;
  logic is_empty;
  logic [CntW-1:0] cnt_last;

  assign cmp_eq   = (rd_data == key_q);
  assign cmp_lt   = ($signed(key_q) < $signed(rd_data));
  assign is_empty = (cnt_q == '0);
  assign cnt_last = cnt_q - CntW'(1);

  fqss_ram #(
    .Width (WordW),
    .Depth (fqss_pkg::DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d  = state_q;
    fp_d     = fp_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    pos_d    = pos_q;
    jpos_d   = jpos_q;
    idx_d    = idx_q;
    found_d  = found_q;
    status_d = status_q;
    front_d  = front_q;
    done_d   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = fp_q;
    wr_data  = key_q;
    rd_addr  = fp_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          found_d  = 1'b0;
          idx_d    = '0;
          status_d = fqss_pkg::ST_OK;
          key_d    = operand_value_i;
          state_d  = S_FRD;
          unique case (opcode_i)
            fqss_pkg::OP_PUSH: begin
              if (cnt_q == fqss_pkg::CNT_FULL) begin
                status_d = fqss_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = fqss_pkg::slot_of(fp_q, cnt_q);
                wr_data = operand_value_i;
                cnt_d   = cnt_q + CntW'(1);
              end
            end
            fqss_pkg::OP_POP: begin
              if (is_empty) begin
                status_d = fqss_pkg::ST_EMPTY;
              end else begin
                fp_d  = fqss_pkg::slot_of(fp_q, CntW'(1));
                cnt_d = cnt_last;
              end
            end
            fqss_pkg::OP_ROT: begin
              if (is_empty) begin
                status_d = fqss_pkg::ST_EMPTY;
              end else begin
                rd_addr = fp_q;
                state_d = S_ROT;
              end
            end
            fqss_pkg::OP_SEARCH: begin
              if (!is_empty) begin
                pos_d   = '0;
                rd_addr = fp_q;
                state_d = S_SRCH;
              end
            end
            fqss_pkg::OP_SORT: begin
              if (cnt_q > CntW'(1)) begin
                jpos_d  = PtrW'(1);
                rd_addr = fqss_pkg::slot_of(fp_q, CntW'(1));
                state_d = S_KEY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ROT: begin
        // rear slot after the move is the old front plus count
        wr_en   = 1'b1;
        wr_addr = fqss_pkg::slot_of(fp_q, cnt_q);
        wr_data = rd_data;
        fp_d    = fqss_pkg::slot_of(fp_q, CntW'(1));
        state_d = S_FRD;
      end

      S_SRCH: begin
        if (cmp_eq) begin
          idx_d   = pos_q;
          found_d = 1'b1;
        end
        if (CntW'(pos_q) == cnt_last) begin
          state_d = S_FRD;
        end else begin
          pos_d   = pos_q + PtrW'(1);
          rd_addr = fqss_pkg::slot_of(fp_q, CntW'(pos_q) + CntW'(1));
        end
      end

      S_KEY: begin
        key_d   = rd_data;
        pos_d   = jpos_q;
        rd_addr = fqss_pkg::slot_of(fp_q, CntW'(jpos_q) - CntW'(1));
        state_d = S_CMP;
      end

      S_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // left neighbor moves one place right
          wr_addr = fqss_pkg::slot_of(fp_q, CntW'(pos_q));
          wr_data = rd_data;
          pos_d   = pos_q - PtrW'(1);
          if (pos_q == PtrW'(1)) begin
            state_d = S_PUT;
          end else begin
            rd_addr = fqss_pkg::slot_of(fp_q, CntW'(pos_q) - CntW'(2));
          end
        end else begin
          wr_addr = fqss_pkg::slot_of(fp_q, CntW'(pos_q));
          wr_data = key_q;
          if (CntW'(jpos_q) == cnt_last) begin
            state_d = S_FRD;
          end else begin
            jpos_d  = jpos_q + PtrW'(1);
            rd_addr = fqss_pkg::slot_of(fp_q, CntW'(jpos_q) + CntW'(1));
            state_d = S_KEY;
          end
        end
      end

      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = fp_q;
        wr_data = key_q;
        if (CntW'(jpos_q) == cnt_last) begin
          state_d = S_FRD;
        end else begin
          jpos_d  = jpos_q + PtrW'(1);
          rd_addr = fqss_pkg::slot_of(fp_q, CntW'(jpos_q) + CntW'(1));
          state_d = S_KEY;
        end
      end

      S_FRD: begin
        rd_addr = fp_q;
        state_d = S_FWAIT;
      end

      S_FWAIT: begin
        front_d = is_empty ? '0 : rd_data;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fp_q     <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= fqss_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      fp_q     <= fp_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    pos_q   <= pos_d;
    jpos_q  <= jpos_d;
    idx_q   <= idx_d;
    front_q <= front_d;
  end

  // result word, held stable while done_o is high
  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign front_value_o = front_q;
  assign entry_count_o = cnt_q;
  assign is_empty_o    = is_empty;
  assign match_index_o = idx_q;
  assign match_found_o = found_q;
  assign status_o      = status_q;

  // checks
  `FQSS_ASSERT(a_accept_goes_busy, (start_i && !busy_o) |=> busy_o, "accepted command did not raise busy")
  `FQSS_ASSERT(a_done_after_front, done_o |-> $past(state_q == S_FWAIT), "result strobe without front read")
  `FQSS_ASSERT(a_full_push_drop, (start_i && !busy_o && opcode_i == fqss_pkg::OP_PUSH && cnt_q == fqss_pkg::CNT_FULL) |=> (cnt_q == $past(cnt_q)), "push on full changed count")
  `FQSS_ASSERT_NEVER(a_count_range, cnt_q > fqss_pkg::CNT_FULL, "entry count beyond depth")

endmodule

// ===== tb/sv/fifo_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_checker
// watches the command and result ports, keeps its own copy of the queue and
// compares every result word against the queue state it predicts
// ----------------------------------------------------------------------------
module fifo_queue_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] operand_value_i,
  input  logic               done_i,
  input  logic signed [31:0] front_value_i,
  input  logic [4:0]         entry_count_i,
  input  logic               is_empty_i,
  input  logic [3:0]         match_index_i,
  input  logic               match_found_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned PRINT_CAP = 60;

  typedef struct packed {
    logic signed [31:0] front;
    logic [4:0]         count;
    logic               empty;
    logic [3:0]         index;
    logic               found;
    logic [1:0]         status;
  } queue_view_t;

  logic [fqss_pkg::WORD_W-1:0] slot_mem [fqss_pkg::DEPTH];
  int                head_slot;
  int                fill_level;
  queue_view_t       expected_views [$];
  queue_view_t       want;
  int                fails = 0;

  assign fail_count_o = fails;

  function automatic int ring_slot(int pos);
    return (head_slot + pos) % fqss_pkg::DEPTH;
  endfunction

  // stable insertion sort over the occupied positions, signed order
  function automatic void sort_ascending();
    logic signed [fqss_pkg::WORD_W-1:0] vals [fqss_pkg::DEPTH];
    logic signed [fqss_pkg::WORD_W-1:0] key;
    int i;
    int j;
    for (i = 0; i < fill_level; i++) vals[i] = slot_mem[ring_slot(i)];
    for (j = 1; j < fill_level; j++) begin
      key = vals[j];
      i = j;
      while (i > 0 && key < vals[i-1]) begin
        vals[i] = vals[i-1];
        i--;
      end
      vals[i] = key;
    end
    for (i = 0; i < fill_level; i++) slot_mem[ring_slot(i)] = vals[i];
  endfunction

  function automatic queue_view_t apply_command(logic [2:0] op, logic signed [31:0] val);
    queue_view_t                 v;
    logic [fqss_pkg::WORD_W-1:0] lead;
    int                          i;
    v = '0;
    case (op)
      fqss_pkg::OP_PUSH: begin
        if (fill_level >= fqss_pkg::DEPTH) begin
          v.status = fqss_pkg::ST_FULL;
        end else begin
          slot_mem[ring_slot(fill_level)] = val;
          fill_level++;
        end
      end
      fqss_pkg::OP_POP, fqss_pkg::OP_ROT: begin
        if (fill_level == 0) begin
          v.status = fqss_pkg::ST_EMPTY;
        end else begin
          lead = slot_mem[head_slot];
          head_slot = (head_slot + 1) % fqss_pkg::DEPTH;
          if (op == fqss_pkg::OP_POP) begin
            fill_level--;
          end else begin
            slot_mem[ring_slot(fill_level - 1)] = lead;
          end
        end
      end
      fqss_pkg::OP_SEARCH: begin
        for (i = 0; i < fill_level; i++) begin
          if (slot_mem[ring_slot(i)] == val) begin
            v.index = 4'(i);
            v.found = 1'b1;
          end
        end
      end
      fqss_pkg::OP_SORT: begin
        sort_ascending();
      end
      default: ;
    endcase
    if (fill_level != 0) v.front = slot_mem[head_slot];
    v.count = 5'(fill_level);
    v.empty = (fill_level == 0);
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    if (fails < PRINT_CAP) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    end
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_slot = 0;
      fill_level = 0;
      expected_views.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_views.size() == 0) begin
          report_mismatch("result word with no command outstanding", 1, 0);
        end else begin
          want = expected_views.pop_front();
          if (front_value_i !== want.front)
            report_mismatch("front_value", front_value_i, want.front);
          if (entry_count_i !== want.count)
            report_mismatch("entry_count", entry_count_i, want.count);
          if (is_empty_i !== want.empty)
            report_mismatch("is_empty", is_empty_i, want.empty);
          if (match_index_i !== want.index)
            report_mismatch("match_index", match_index_i, want.index);
          if (match_found_i !== want.found)
            report_mismatch("match_found", match_found_i, want.found);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
        end
      end
      if (start_i && !busy_i) begin
        expected_views = {expected_views, apply_command(opcode_i, operand_value_i)};
      end
      pending_o <= expected_views.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives command words into the queue block, a directed opening then biased
// random fill and drain traffic over several sender idle phases; the checker
// beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned ITEMS_PER_PHASE = 375;
  // worst sort on a full queue is well under this
  localparam int unsigned DRAIN_CYCLES    = 400;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  // opcodes the block treats as no operation
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [2:0]         opcode_i = fqss_pkg::OP_PUSH;
  logic signed [31:0] operand_value_i = '0;

  logic               busy_o;
  logic               done_o;
  logic signed [31:0] front_value_o;
  logic [4:0]         entry_count_o;
  logic               is_empty_o;
  logic [3:0]         match_index_o;
  logic               match_found_o;
  logic [1:0]         status_o;

  int fail_count;
  int pending;
  int idle_pct;

  // mixed order with repeats so the directed sort has real work and the
  // last-match search sees several equal entries
  logic signed [31:0] fill_vals [15] = '{
    WORD_MAX, 32'sd5, -32'sd1, 32'sd0, 32'sd5, WORD_MIN, 32'sd100, -32'sd1,
    32'sd5, 32'sh55555555, 32'shaaaaaaaa, 32'sd0, -32'sd7, 32'sd3, 32'sd5
  };

  fifo_queue_sort_search_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .front_value_o   (front_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .match_index_o   (match_index_o),
    .match_found_o   (match_found_o),
    .status_o        (status_o)
  );

  fifo_queue_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .done_i          (done_o),
    .front_value_i   (front_value_o),
    .entry_count_i   (entry_count_o),
    .is_empty_i      (is_empty_o),
    .match_index_i   (match_index_o),
    .match_found_i   (match_found_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #50ms;
    $display("FAIL fifo_queue_sort_search_top");
    $finish;
  end

  // one command word: optional idle cycles first, then hold start_i until
  // an edge sees busy_o low; called and returning at a rising edge
  task automatic send_word(logic [2:0] op, logic signed [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    operand_value_i <= val;
    do @(posedge clk_i); while (busy_o);
  endtask

  // mostly a small value pool so searches hit and sorts see ties,
  // sometimes full-width noise and the two's complement corners
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed(32'($urandom_range(0, 8))) - 32'sd4;
    if (r < 8) return $signed($urandom);
    case ($urandom_range(0, 3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // filling leans on push, draining on pop, so the queue swings between
  // empty and full over and over
  function automatic logic [2:0] pick_op(bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (r < 13) return fqss_pkg::OP_ROT;
    if (r < 25) return fqss_pkg::OP_SEARCH;
    if (r < 31) return fqss_pkg::OP_SORT;
    if (r < 78) return filling ? fqss_pkg::OP_PUSH : fqss_pkg::OP_POP;
    return filling ? fqss_pkg::OP_POP : fqss_pkg::OP_PUSH;
  endfunction

  initial begin
    int          phase_pct [4];
    int          p;
    int          n;
    int          run_left;
    int          waited;
    bit          filling;
    logic [2:0]  op;
    phase_pct = '{0, 59, 0, 31};
    idle_pct = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corners
    send_word(fqss_pkg::OP_POP, 32'sd0);
    send_word(fqss_pkg::OP_ROT, 32'sd0);
    send_word(fqss_pkg::OP_SEARCH, 32'sd0);
    send_word(fqss_pkg::OP_SORT, 32'sd0);
    send_word(OP_UNUSED_LO, WORD_MAX);
    // single entry sort and rotate
    send_word(fqss_pkg::OP_PUSH, WORD_MIN);
    send_word(fqss_pkg::OP_SORT, 32'sd0);
    send_word(fqss_pkg::OP_ROT, 32'sd0);
    // fill to the top, then push on full and rotate on full
    for (n = 0; n < 15; n++) send_word(fqss_pkg::OP_PUSH, fill_vals[n]);
    send_word(fqss_pkg::OP_PUSH, 32'sd123);
    send_word(fqss_pkg::OP_ROT, 32'sd0);
    send_word(fqss_pkg::OP_SEARCH, 32'sd5);
    send_word(fqss_pkg::OP_SORT, 32'sd0);
    send_word(fqss_pkg::OP_SEARCH, -32'sd1);
    send_word(OP_UNUSED_HI, WORD_MIN);

    // random traffic, one idle setting per phase
    filling = 1'b1;
    run_left = 0;
    for (p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          filling = ~filling;
          run_left = $urandom_range(20, 60);
        end
        run_left--;
        op = pick_op(filling);
        send_word(op, pick_value());
      end
    end
    start_i <= 1'b0;

    // let every outstanding result word come back, then a quiet tail
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS fifo_queue_sort_search_top");
    end else begin
      $display("FAIL fifo_queue_sort_search_top");
    end
    $finish;
  end

endmodule
